>>> hw/rtl/assert_macros.svh
// Assertion helpers; they vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hw/rtl/ecu_pkg.sv
package ecu_pkg;

	typedef logic [32:0] val_t;

	localparam val_t ONE30       = 33'h0_4000_0000;
	localparam val_t TWO30       = 33'h0_8000_0000;
	localparam val_t HALF30      = 33'h0_2000_0000;
	localparam val_t PI_HALF30   = 33'd1686629713;
	localparam val_t PI_QUART30  = 33'd843314857;
	localparam val_t LN2_30      = 33'd744261118;
	localparam logic [4:0] LAST_OP = 5'd17;
	localparam int unsigned HORNER_STAGES = 12;

	typedef enum logic [1:0] {MODE_POLY, MODE_SINE, MODE_EXPO} mode_t;
	typedef enum logic [1:0] {FORM_IN, FORM_OUT, FORM_INOUT} form_t;

	typedef struct packed {
		mode_t      mode;
		form_t      form;
		logic       bad;
		logic       force_en;
		logic       force_one;
		logic       lower;
		logic [3:0] shift_n;
		logic [3:0] steps;
		val_t       c;
		val_t       h;
		val_t       src;
		val_t       a;
	} item_t;

	// Product of two UQ.30 values, rounded half up.
	function automatic val_t mul30(val_t x, val_t y);
		logic [65:0] prod;
		prod = {33'b0, x} * {33'b0, y};
		prod = prod + 66'(HALF30);
		return prod[62:30];
	endfunction

	// Truncating divide by a small constant k, recip = floor(2^33 / k).
	// The reciprocal estimate is low by at most one, fixed by one compare.
	function automatic val_t div_const(val_t src, logic [7:0] k, logic [33:0] recip);
		logic [66:0] prod;
		val_t        q0;
		logic [40:0] back;
		val_t        rem;
		prod = {34'b0, src} * {33'b0, recip};
		q0   = prod[65:33];
		back = {8'b0, q0} * {33'b0, k};
		rem  = src - back[32:0];
		if (rem >= val_t'(k)) begin
			q0 = q0 + 33'd1;
		end
		return q0;
	endfunction

	function automatic int unsigned sine_div(int unsigned i);
		case (i)
			0: return 156;
			1: return 110;
			2: return 72;
			3: return 42;
			4: return 20;
			5: return 6;
			default: return 1;
		endcase
	endfunction

endpackage

>>> hw/rtl/easing_curve_unit.sv
// Easing curve unit: evaluates one of eighteen easing curves (sine, quad,
// cubic, quart, quint and base-2 expo, each in, out and in-out) at a
// progress value x in UQ1.FRAC_BITS and returns the eased value, clamped
// to 0..1.0, in the same format.
// Input channel: operation and progress are taken as one beat at a rising
// edge where start is high and busy is low. Busy never rises, so a new beat
// may be started in every cycle.
// Output channel: done is high for exactly one cycle with eased_value and
// bad_selector; the receiver must take the beat in that cycle.
// Throughput is one beat per cycle. The pipeline is built around the
// twelve-step Horner chain of the exponential series, one multiply per
// stage, plus the angle, square and final rounding stages around it.
// An operation above 17 returns zero with bad_selector set.
// Reset clears the valid bits of all stages; beats in flight are dropped
// and done stays low until new beats come through.
module easing_curve_unit #(
	parameter int unsigned FRAC_BITS = 15
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [4:0]           operation,
	input  logic [FRAC_BITS:0]   progress,
	output logic                 done,
	output logic [FRAC_BITS:0]   eased_value,
	output logic                 bad_selector
);

`include "assert_macros.svh"

	localparam int unsigned SH = 30 - FRAC_BITS;
	localparam logic [FRAC_BITS:0] ONE_F = {1'b1, {FRAC_BITS{1'b0}}};
	localparam ecu_pkg::val_t RND = ecu_pkg::val_t'((64'd1 << SH) >> 1);
	localparam logic [33:0] SREC0 = 34'((64'd1 << 33) / ecu_pkg::sine_div(0));
	localparam logic [33:0] EREC0 = 34'((64'd1 << 33) / 12);
	localparam logic [35:0] ONE36 = 36'h0_4000_0000;

	assign busy = 1'b0;

	// Stage 1: input register.
	logic                 v_s1;
	logic [4:0]           op_s1;
	logic [FRAC_BITS:0]   prog_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= operation;
		prog_s1 <= progress;
	end

	// Stage 2: decode, curve base values and the sine angle multiply.
	logic [FRAC_BITS:0] x_sat;
	ecu_pkg::val_t      x30;
	logic [2:0]         family;
	logic [4:0]         fam3;
	logic [4:0]         form_code;
	logic [35:0]        x36;
	logic [35:0]        w;
	ecu_pkg::item_t     nx2;
	ecu_pkg::item_t     st_s2;
	logic               v_s2;

	always_comb begin
		x_sat = (prog_s1 > ONE_F) ? ONE_F : prog_s1;
		x30   = ecu_pkg::val_t'(x_sat) << SH;
		x36   = 36'(x30);
		if (op_s1 < 5'd3) begin
			family = 3'd0;
		end else if (op_s1 < 5'd6) begin
			family = 3'd1;
		end else if (op_s1 < 5'd9) begin
			family = 3'd2;
		end else if (op_s1 < 5'd12) begin
			family = 3'd3;
		end else if (op_s1 < 5'd15) begin
			family = 3'd4;
		end else if (op_s1 < 5'd18) begin
			family = 3'd5;
		end else begin
			family = 3'd6;
		end
		fam3      = {2'b0, family} + {1'b0, family, 1'b0};
		form_code = op_s1 - fam3;

		nx2       = '0;
		nx2.bad   = op_s1 > ecu_pkg::LAST_OP;
		nx2.lower = x30 < ecu_pkg::HALF30;
		case (form_code[1:0])
			2'd0: nx2.form = ecu_pkg::FORM_IN;
			2'd1: nx2.form = ecu_pkg::FORM_OUT;
			2'd2: nx2.form = ecu_pkg::FORM_INOUT;
			default: nx2.form = ecu_pkg::FORM_IN;
		endcase

		case (nx2.form)
			ecu_pkg::FORM_IN:  w = 36'd10 * (ONE36 - x36);
			ecu_pkg::FORM_OUT: w = 36'd10 * x36;
			default: begin
				if (nx2.lower) begin
					w = 36'd11 * ONE36 - 36'd20 * x36;
				end else begin
					w = 36'd20 * x36 - 36'd9 * ONE36;
				end
			end
		endcase

		case (family)
			3'd0: begin
				nx2.mode = ecu_pkg::MODE_SINE;
				nx2.steps = 4'd6;
				nx2.a = ecu_pkg::mul30(x30, (nx2.form == ecu_pkg::FORM_IN) ?
					ecu_pkg::PI_QUART30 : ecu_pkg::PI_HALF30);
			end
			3'd5: begin
				nx2.mode    = ecu_pkg::MODE_EXPO;
				nx2.shift_n = w[33:30];
				nx2.src     = ecu_pkg::ONE30 - ecu_pkg::val_t'(w[29:0]);
				nx2.steps   = (w[29:0] == '0) ? 4'd0 : 4'd12;
				case (nx2.form)
					ecu_pkg::FORM_IN: begin
						nx2.force_en = (x30 == '0);
					end
					ecu_pkg::FORM_OUT: begin
						nx2.force_en  = (x30 == ecu_pkg::ONE30);
						nx2.force_one = 1'b1;
					end
					default: begin
						nx2.force_en  = (x30 == '0) || (x30 == ecu_pkg::ONE30);
						nx2.force_one = (x30 == ecu_pkg::ONE30);
					end
				endcase
			end
			default: begin
				nx2.mode  = ecu_pkg::MODE_POLY;
				nx2.steps = {1'b0, family};
				case (nx2.form)
					ecu_pkg::FORM_IN:  nx2.src = x30;
					ecu_pkg::FORM_OUT: nx2.src = ecu_pkg::ONE30 - x30;
					default: begin
						nx2.src = nx2.lower ? (x30 << 1) : (ecu_pkg::TWO30 - (x30 << 1));
					end
				endcase
			end
		endcase

		if (nx2.bad) begin
			nx2.force_en  = 1'b1;
			nx2.force_one = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		st_s2 <= nx2;
	end

	// Stage 3: square of the angle, or the scaled exponent fraction.
	ecu_pkg::item_t nx3;
	ecu_pkg::item_t st_s3;
	logic           v_s3;

	always_comb begin
		nx3 = st_s2;
		case (st_s2.mode)
			ecu_pkg::MODE_SINE: nx3.src = ecu_pkg::mul30(st_s2.a, st_s2.a);
			ecu_pkg::MODE_EXPO: nx3.src = ecu_pkg::mul30(st_s2.src, ecu_pkg::LN2_30);
			default: nx3.src = st_s2.src;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		st_s3 <= nx3;
	end

	// Stage 4: first series coefficient and start value. Its register is
	// the head of the Horner chain, hrn_s[0].
	ecu_pkg::item_t nx4;
	ecu_pkg::item_t hrn_s [ecu_pkg::HORNER_STAGES+1];
	logic           hv_s  [ecu_pkg::HORNER_STAGES+1];

	always_comb begin
		nx4 = st_s3;
		case (st_s3.mode)
			ecu_pkg::MODE_SINE: begin
				nx4.c = ecu_pkg::div_const(st_s3.src, 8'(ecu_pkg::sine_div(0)), SREC0);
				nx4.h = ecu_pkg::ONE30;
			end
			ecu_pkg::MODE_EXPO: begin
				nx4.c = ecu_pkg::div_const(st_s3.src, 8'd12, EREC0);
				nx4.h = (st_s3.steps == '0) ? ecu_pkg::TWO30 : ecu_pkg::ONE30;
			end
			default: begin
				nx4.c = st_s3.src;
				nx4.h = st_s3.src;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_s[0] <= 1'b0;
		end else begin
			hv_s[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		hrn_s[0] <= nx4;
	end

	// Horner chain: one multiply per stage, while the divider for the next
	// stage's coefficient works in parallel. Items needing fewer steps pass.
	for (genvar j = 0; j < ecu_pkg::HORNER_STAGES; j++) begin : g_horner
		localparam int unsigned SK = ecu_pkg::sine_div(j + 1);
		localparam int unsigned EK = (j < 11) ? (11 - j) : 1;
		localparam logic [33:0] SREC = 34'((64'd1 << 33) / SK);
		localparam logic [33:0] EREC = 34'((64'd1 << 33) / EK);

		ecu_pkg::item_t nx_h;
		ecu_pkg::val_t  m_h;

		always_comb begin
			nx_h = hrn_s[j];
			m_h  = ecu_pkg::mul30(hrn_s[j].c, hrn_s[j].h);
			if (hrn_s[j].steps > 4'(j)) begin
				case (hrn_s[j].mode)
					ecu_pkg::MODE_SINE: nx_h.h = ecu_pkg::ONE30 - m_h;
					ecu_pkg::MODE_EXPO: nx_h.h = ecu_pkg::ONE30 + m_h;
					default: nx_h.h = m_h;
				endcase
			end
			case (hrn_s[j].mode)
				ecu_pkg::MODE_SINE: nx_h.c = ecu_pkg::div_const(hrn_s[j].src, 8'(SK), SREC);
				ecu_pkg::MODE_EXPO: nx_h.c = ecu_pkg::div_const(hrn_s[j].src, 8'(EK), EREC);
				default: nx_h.c = hrn_s[j].src;
			endcase
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hv_s[j+1] <= 1'b0;
			end else begin
				hv_s[j+1] <= hv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			hrn_s[j+1] <= nx_h;
		end
	end

	// P1: sine times angle, or the exponent shift with round half up.
	ecu_pkg::item_t nxp1;
	ecu_pkg::item_t hl;
	ecu_pkg::val_t  ex_r;
	ecu_pkg::item_t st_s5;
	logic           v_s5;

	always_comb begin
		hl   = hrn_s[ecu_pkg::HORNER_STAGES];
		nxp1 = hl;
		ex_r = (hl.h + (ecu_pkg::val_t'(1) << hl.shift_n)) >> ({1'b0, hl.shift_n} + 5'd1);
		case (hl.mode)
			ecu_pkg::MODE_SINE: nxp1.h = ecu_pkg::mul30(hl.a, hl.h);
			ecu_pkg::MODE_EXPO: nxp1.h = (ex_r > ecu_pkg::ONE30) ? ecu_pkg::ONE30 : ex_r;
			default: nxp1.h = hl.h;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= hv_s[ecu_pkg::HORNER_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		st_s5 <= nxp1;
	end

	// P2: form the in, out or in-out curve and apply the forced end points.
	ecu_pkg::val_t sq;
	ecu_pkg::val_t half_p;
	ecu_pkg::val_t r_nx;
	ecu_pkg::val_t r_s6;
	logic          bad_s6;
	logic          v_s6;

	always_comb begin
		sq     = ecu_pkg::mul30(st_s5.h, st_s5.h);
		half_p = (st_s5.h + 33'd1) >> 1;
		case (st_s5.mode)
			ecu_pkg::MODE_SINE: begin
				case (st_s5.form)
					ecu_pkg::FORM_IN:  r_nx = sq << 1;
					ecu_pkg::FORM_OUT: r_nx = st_s5.h;
					default: r_nx = sq;
				endcase
			end
			ecu_pkg::MODE_EXPO: begin
				case (st_s5.form)
					ecu_pkg::FORM_IN:  r_nx = st_s5.h;
					ecu_pkg::FORM_OUT: r_nx = ecu_pkg::ONE30 - st_s5.h;
					default: r_nx = st_s5.lower ? st_s5.h : ecu_pkg::ONE30 - st_s5.h;
				endcase
			end
			default: begin
				case (st_s5.form)
					ecu_pkg::FORM_IN:  r_nx = st_s5.h;
					ecu_pkg::FORM_OUT: r_nx = ecu_pkg::ONE30 - st_s5.h;
					default: r_nx = st_s5.lower ? half_p : ecu_pkg::ONE30 - half_p;
				endcase
			end
		endcase
		if (st_s5.force_en) begin
			r_nx = st_s5.force_one ? ecu_pkg::ONE30 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		r_s6   <= r_nx;
		bad_s6 <= st_s5.bad;
	end

	// Output register: clamp to 1.0 and round to FRAC_BITS fraction bits.
	ecu_pkg::val_t      r_cl;
	ecu_pkg::val_t      r_rnd;
	logic [FRAC_BITS:0] out_nx;

	always_comb begin
		r_cl  = (r_s6 > ecu_pkg::ONE30) ? ecu_pkg::ONE30 : r_s6;
		r_rnd = (r_cl + RND) >> SH;
		out_nx = (r_rnd > ecu_pkg::val_t'(ONE_F)) ? ONE_F : r_rnd[FRAC_BITS:0];
		if (bad_s6) begin
			out_nx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		eased_value  <= out_nx;
		bad_selector <= bad_s6;
	end

	`ASSERT_IMP(a_bad_gives_zero, clk, arst_n, done && bad_selector, eased_value == '0)
	`ASSERT_IMP(a_value_in_range, clk, arst_n, done, eased_value <= ONE_F)
	`ASSERT_IMP(a_expo_shift_range, clk, arst_n, hv_s[0] && hrn_s[0].mode == ecu_pkg::MODE_EXPO, hrn_s[0].shift_n <= 4'd11)
	`ASSERT_NXT(a_done_follows_s6, clk, arst_n, v_s6, done)

endmodule

>>> tb/sv/easing_curve_unit_test.sv
module easing_curve_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = 15;
	localparam int LATENCY = 18;
	localparam logic [63:0] Q_ONE = 64'd1 << 30;
	localparam logic [63:0] Q_HALF = 64'd1 << 29;
	localparam logic [63:0] PI_HALF_Q = 64'd1686629713;
	localparam logic [63:0] PI_QUARTER_Q = 64'd843314857;
	localparam logic [63:0] LN2_Q = 64'd744261118;

	typedef enum int {FAM_SINE, FAM_QUAD, FAM_CUBIC, FAM_QUART, FAM_QUINT, FAM_EXPO} family_t;
	typedef enum int {SHAPE_IN, SHAPE_OUT, SHAPE_INOUT} shape_t;

	typedef struct {
		logic [FB:0] value;
		logic        bad;
	} eased_t;

	typedef struct {
		logic [4:0]  op;
		logic [FB:0] x;
		logic        typed;
		logic [FB:0] value;
		logic        bad;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [4:0] operation = '0;
	logic [FB:0] progress = '0;
	logic busy, done, bad_selector;
	logic [FB:0] eased_value;

	eased_t pending_results[$];
	int errors = 0;
	int beats_sent = 0;
	int beats_checked = 0;
	int idle_pct = 0;

	easing_curve_unit #(.FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .progress(progress), .done(done),
		.eased_value(eased_value), .bad_selector(bad_selector)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
		return (a * b + Q_HALF) >> 30;
	endfunction

	function automatic logic [63:0] qpow(logic [63:0] b, int n);
		logic [63:0] p;
		p = b;
		for (int i = 1; i < n; i++) p = qmul(p, b);
		return p;
	endfunction

	function automatic logic [63:0] qsin(logic [63:0] a);
		logic [63:0] z, h;
		int divs[6];
		divs = '{156, 110, 72, 42, 20, 6};
		z = qmul(a, a);
		h = Q_ONE;
		for (int i = 0; i < 6; i++) h = Q_ONE - qmul(z / divs[i], h);
		return qmul(a, h);
	endfunction

	function automatic logic [63:0] exp2_neg(logic [63:0] w);
		logic [63:0] n, f, v, r, t;
		n = w >> 30;
		f = w & (Q_ONE - 1);
		if (n > 40) return 0;
		if (f == 0) begin
			v = 2 * Q_ONE;
		end else begin
			t = qmul(Q_ONE - f, LN2_Q);
			v = Q_ONE;
			for (int k = 12; k >= 1; k--) v = Q_ONE + qmul(t / k, v);
		end
		r = (v + (64'd1 << n)) >> (n + 1);
		return r > Q_ONE ? Q_ONE : r;
	endfunction

	function automatic logic [63:0] curve_q30(int fam, int shape, logic [63:0] x);
		logic [63:0] s;
		int n;
		if (fam == FAM_SINE) begin
			if (shape == SHAPE_IN) begin
				s = qsin(qmul(x, PI_QUARTER_Q));
				return 2 * qmul(s, s);
			end
			s = qsin(qmul(x, PI_HALF_Q));
			return shape == SHAPE_OUT ? s : qmul(s, s);
		end
		if (fam == FAM_EXPO) begin
			if (shape == SHAPE_IN) return x == 0 ? 0 : exp2_neg(10 * (Q_ONE - x));
			if (shape == SHAPE_OUT) return x == Q_ONE ? Q_ONE : Q_ONE - exp2_neg(10 * x);
			if (x == 0) return 0;
			if (x == Q_ONE) return Q_ONE;
			if (x < Q_HALF) return exp2_neg(11 * Q_ONE - 20 * x);
			return Q_ONE - exp2_neg(20 * x - 9 * Q_ONE);
		end
		n = fam + 1;
		if (shape == SHAPE_IN) return qpow(x, n);
		if (shape == SHAPE_OUT) return Q_ONE - qpow(Q_ONE - x, n);
		if (x < Q_HALF) return (qpow(2 * x, n) + 1) >> 1;
		return Q_ONE - ((qpow(2 * Q_ONE - 2 * x, n) + 1) >> 1);
	endfunction

	function automatic eased_t ease(logic [4:0] op, logic [FB:0] x_in);
		eased_t e;
		logic [63:0] x, r;
		if (op > ecu_pkg::LAST_OP) begin
			e.value = '0;
			e.bad = 1'b1;
			return e;
		end
		x = 64'(x_in);
		if (x > (64'd1 << FB)) x = 64'd1 << FB;
		r = curve_q30(int'(op / 5'd3), int'(op % 5'd3), x << (30 - FB));
		if (r > Q_ONE) r = Q_ONE;
		r = (r + (64'd1 << (29 - FB))) >> (30 - FB);
		if (r > (64'd1 << FB)) r = 64'd1 << FB;
		e.value = r[FB:0];
		e.bad = 1'b0;
		return e;
	endfunction

	// Sends one beat, with a random idle gap ahead of it. Start stays high
	// after the beat so back-to-back beats need no extra assignment.
	task automatic send_beat(logic [4:0] op, logic [FB:0] x, eased_t want);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		operation <= op;
		progress <= x;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(want);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_random(int count);
		logic [4:0] op;
		logic [FB:0] x;
		for (int i = 0; i < count; i++) begin
			op = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(17));
			case ($urandom_range(7))
				0: x = 16'($urandom_range(65535));
				1: x = 16'($urandom_range(4));
				2: x = 16'(32768 - $urandom_range(4));
				3: x = 16'(16384 + $urandom_range(4) - 2);
				default: x = 16'($urandom_range(32768));
			endcase
			send_beat(op, x, ease(op, x));
		end
	endtask

	always @(posedge clk) begin
		eased_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected beat value=%0d bad=%0b", $realtime,
					eased_value, bad_selector);
				errors++;
			end else begin
				want = pending_results.pop_front();
				beats_checked++;
				if (eased_value !== want.value) begin
					$display("%0t: eased_value expected %0d actual %0d", $realtime,
						want.value, eased_value);
					errors++;
				end
				if (bad_selector !== want.bad) begin
					$display("%0t: bad_selector expected %0b actual %0b", $realtime,
						want.bad, bad_selector);
					errors++;
				end
			end
		end
	end

	initial begin
		#50ms;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		row_t rows[$];
		eased_t want;
		rows = '{
			'{5'd0, 16'd0, 1'b1, 16'd0, 1'b0},
			'{5'd1, 16'd32768, 1'b1, 16'd32768, 1'b0},
			'{5'd3, 16'd32768, 1'b1, 16'd32768, 1'b0},
			'{5'd3, 16'd0, 1'b1, 16'd0, 1'b0},
			'{5'd15, 16'd0, 1'b1, 16'd0, 1'b0},
			'{5'd16, 16'd32768, 1'b1, 16'd32768, 1'b0},
			'{5'd17, 16'd0, 1'b1, 16'd0, 1'b0},
			'{5'd17, 16'd32768, 1'b1, 16'd32768, 1'b0},
			'{5'd18, 16'd100, 1'b1, 16'd0, 1'b1},
			'{5'd31, 16'd65535, 1'b1, 16'd0, 1'b1},
			'{5'd4, 16'd65535, 1'b1, 16'd32768, 1'b0},
			'{5'd15, 16'd32768, 1'b0, 16'd0, 1'b0},
			'{5'd16, 16'd0, 1'b0, 16'd0, 1'b0},
			'{5'd17, 16'd16384, 1'b0, 16'd0, 1'b0},
			'{5'd17, 16'd16383, 1'b0, 16'd0, 1'b0},
			'{5'd2, 16'd16384, 1'b0, 16'd0, 1'b0},
			'{5'd5, 16'd16385, 1'b0, 16'd0, 1'b0},
			'{5'd8, 16'd1, 1'b0, 16'd0, 1'b0},
			'{5'd11, 16'd32767, 1'b0, 16'd0, 1'b0},
			'{5'd13, 16'd12345, 1'b0, 16'd0, 1'b0},
			'{5'd0, 16'd32768, 1'b0, 16'd0, 1'b0},
			'{5'd1, 16'd21845, 1'b0, 16'd0, 1'b0},
			'{5'd6, 16'd40000, 1'b0, 16'd0, 1'b0}
		};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (rows[i]) begin
			if (rows[i].typed) begin
				want.value = rows[i].value;
				want.bad = rows[i].bad;
			end else begin
				want = ease(rows[i].op, rows[i].x);
			end
			send_beat(rows[i].op, rows[i].x, want);
		end
		start <= 1'b0;
		// Hold off until the pipeline has drained completely.
		while (pending_results.size() != 0) @(negedge clk);
		idle_pct = 18;
		send_random(250);
		idle_pct = 73;
		send_random(250);
		idle_pct = 0;
		send_random(250);
		start <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
		$display("Sent %0d beats over all eighteen curves and bad selectors,", beats_sent);
		$display("checked %0d results under three idle patterns.", beats_checked);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
